>>> rtl/core/first_fit_page_run_allocator_core_assert.svh
// Assertion helpers for the page run allocator.
`ifndef FIRST_FIT_PAGE_RUN_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_PAGE_RUN_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define FFPA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffpa: same-cycle check failed");
`define FFPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffpa: next-cycle check failed");
`else
`define FFPA_ASSERT_SAME(label, ante, cons)
`define FFPA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/core/ffpa_pkg.sv
`default_nettype none
package ffpa_pkg;

  localparam int PAGE_SHIFT      = 12;
  localparam int PAGE_BYTES      = 1 << PAGE_SHIFT;
  localparam int NPAGES_DEF      = 1024;
  localparam int MAX_RECORDS_DEF = 256;

  localparam logic [10:0] REGION_PAGES_RST = 11'd1024;
  localparam logic [12:0] SMALL_LIMIT_RST  = 13'd2048;

  typedef enum logic [1:0] {
    CFG_REGION_BASE  = 2'd0,
    CFG_REGION_PAGES = 2'd1,
    CFG_SMALL_LIMIT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SMALL    = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_FULL     = 3'd3,
    ST_OUTSIDE  = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SLOT,
    S_MARK,
    S_FIND,
    S_RELEASE
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] req_bytes;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] start_address;
    logic [10:0] pages;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/core/ffpa_page_mem.sv
`default_nettype none
module ffpa_page_mem #(
  parameter int NPAGES = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(NPAGES)-1:0] addr,
  input  wire logic                      wdata,
  output logic                           rdata
);

  logic used [NPAGES];

  always_ff @(posedge clk) begin
    if (we) begin
      used[addr] <= wdata;
    end
    rdata <= used[addr];
  end

endmodule
`default_nettype wire

>>> rtl/core/ffpa_rec_mem.sv
`default_nettype none
module ffpa_rec_mem #(
  parameter int REC_W   = 8,
  parameter int DEPTH   = 256,
  parameter int ENTRY_W = 22
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [REC_W-1:0]   addr,
  input  wire logic [ENTRY_W-1:0] wdata,
  output logic [ENTRY_W-1:0]      rdata
);

  logic [ENTRY_W-1:0] entry [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      entry[addr] <= wdata;
    end
    rdata <= entry[addr];
  end

endmodule
`default_nettype wire

>>> rtl/core/ffpa_ctrl.sv
`default_nettype none
module ffpa_ctrl
  import ffpa_pkg::*;
#(
  parameter int NPAGES      = NPAGES_DEF,
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire req_t                           req,
  input  wire logic                           clear_req,
  input  wire logic [31:0]                    region_base,
  input  wire logic [$clog2(NPAGES+1)-1:0]    eff_pages,
  input  wire logic [12:0]                    small_limit,
  output logic                                busy,
  output logic                                done,
  output res_t                                result
);

  localparam int PG_W    = $clog2(NPAGES);
  localparam int CNT_W   = $clog2(NPAGES + 1);
  localparam int REC_W   = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CLR_N   = (NPAGES > MAX_RECORDS) ? NPAGES : MAX_RECORDS;
  localparam int IDX_W   = $clog2(CLR_N + 1);
  localparam int ENTRY_W = 1 + PG_W + CNT_W;

  state_t             state, state_next;
  logic [IDX_W-1:0]   cnt, cnt_next;
  logic               chk_vld, chk_vld_next;
  logic [IDX_W-1:0]   chk_idx;
  logic               chk_last;
  logic [CNT_W-1:0]   run;
  logic [PG_W-1:0]    first;
  logic [CNT_W-1:0]   need;
  logic [PG_W-1:0]    tgt;
  logic [REC_W-1:0]   slot;
  logic [CNT_W-1:0]   rcount;
  logic [CNT_W-1:0]   free_pages;

  logic               fin;
  res_t               fin_res;
  logic               hit;

  logic               pg_we, pg_wdata, pg_rdata;
  logic [PG_W-1:0]    pg_addr;
  logic               rec_we;
  logic [REC_W-1:0]   rec_addr;
  logic               rec_wvalid;
  logic [ENTRY_W-1:0] rec_wdata, rec_rdata;
  logic               rec_rvalid;
  logic [PG_W-1:0]    rec_rstart;
  logic [CNT_W-1:0]   rec_rcount;

  logic [31:0]        need_calc;
  logic [31:0]        off;
  logic               pg_iss, rec_iss;

  assign need_calc = 32'(req.req_bytes >> PAGE_SHIFT) + 32'(|req.req_bytes[PAGE_SHIFT-1:0]);
  assign off       = req.address - region_base;
  assign pg_iss    = 32'(cnt) < 32'(eff_pages);
  assign rec_iss   = 32'(cnt) < MAX_RECORDS;
  assign busy      = (state != S_IDLE);

  assign rec_wdata = {rec_wvalid, first, need};
  assign {rec_rvalid, rec_rstart, rec_rcount} = rec_rdata;

  ffpa_page_mem #(.NPAGES(NPAGES)) u_page_mem (
    .clk  (clk),
    .we   (pg_we),
    .addr (pg_addr),
    .wdata(pg_wdata),
    .rdata(pg_rdata)
  );

  ffpa_rec_mem #(.REC_W(REC_W), .DEPTH(MAX_RECORDS), .ENTRY_W(ENTRY_W)) u_rec_mem (
    .clk  (clk),
    .we   (rec_we),
    .addr (rec_addr),
    .wdata(rec_wdata),
    .rdata(rec_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      chk_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      chk_vld <= chk_vld_next;
      done    <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      result <= fin_res;
    end
    case (state)
      S_CLEAR: begin
        free_pages <= eff_pages;
      end
      S_IDLE: begin
        need <= CNT_W'(need_calc);
        tgt  <= PG_W'(off >> PAGE_SHIFT);
        run  <= '0;
      end
      S_SCAN: begin
        chk_idx  <= cnt;
        chk_last <= (32'(cnt) == 32'(eff_pages) - 32'd1);
        if (chk_vld) begin
          if (pg_rdata) begin
            run <= '0;
          end else begin
            if (run == '0) begin
              first <= chk_idx[PG_W-1:0];
            end
            run <= run + 1'b1;
          end
        end
      end
      S_SLOT, S_FIND: begin
        chk_idx  <= cnt;
        chk_last <= (32'(cnt) == MAX_RECORDS - 1);
        if (hit) begin
          slot   <= chk_idx[REC_W-1:0];
          rcount <= rec_rcount;
        end
      end
      S_MARK: begin
        if (fin) begin
          free_pages <= free_pages - need;
        end
      end
      S_RELEASE: begin
        if (fin) begin
          free_pages <= free_pages + rcount;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    chk_vld_next = 1'b0;
    fin          = 1'b0;
    fin_res      = '{status: ST_OK, start_address: '0, pages: '0};
    hit          = 1'b0;
    pg_we        = 1'b0;
    pg_addr      = cnt[PG_W-1:0];
    pg_wdata     = 1'b0;
    rec_we       = 1'b0;
    rec_addr     = cnt[REC_W-1:0];
    rec_wvalid   = 1'b0;

    case (state)
      S_CLEAR: begin
        pg_we    = 32'(cnt) < NPAGES;
        rec_we   = rec_iss;
        cnt_next = cnt + 1'b1;
        if (32'(cnt) == CLR_N - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_next = '0;
        if (start) begin
          if (!req.req_type) begin
            if (req.req_bytes <= 32'(small_limit)) begin
              fin = 1'b1;
              fin_res.status = ST_SMALL;
            end else if (need_calc > 32'(free_pages)) begin
              fin = 1'b1;
              fin_res.status = ST_NOSPACE;
            end else begin
              state_next = S_SCAN;
            end
          end else begin
            if ((off >> PAGE_SHIFT) >= 32'(eff_pages)) begin
              fin = 1'b1;
              fin_res.status = ST_OUTSIDE;
            end else if (off[PAGE_SHIFT-1:0] != '0) begin
              fin = 1'b1;
              fin_res.status = ST_NOTFOUND;
            end else begin
              state_next = S_FIND;
            end
          end
        end
      end
      S_SCAN: begin
        // read of page cnt is in flight while page chk_idx is checked
        chk_vld_next = pg_iss;
        if (pg_iss) begin
          cnt_next = cnt + 1'b1;
        end
        if (chk_vld && !pg_rdata && (run + 1'b1 == need)) begin
          state_next   = S_SLOT;
          cnt_next     = '0;
          chk_vld_next = 1'b0;
        end else if (chk_vld && chk_last) begin
          fin            = 1'b1;
          fin_res.status = ST_NOSPACE;
          state_next     = S_IDLE;
        end
      end
      S_SLOT: begin
        chk_vld_next = rec_iss;
        if (rec_iss) begin
          cnt_next = cnt + 1'b1;
        end
        if (chk_vld && !rec_rvalid) begin
          hit          = 1'b1;
          state_next   = S_MARK;
          cnt_next     = '0;
          chk_vld_next = 1'b0;
        end else if (chk_vld && chk_last) begin
          fin            = 1'b1;
          fin_res.status = ST_FULL;
          state_next     = S_IDLE;
        end
      end
      S_MARK: begin
        pg_we      = 1'b1;
        pg_addr    = first + cnt[PG_W-1:0];
        pg_wdata   = 1'b1;
        rec_addr   = slot;
        rec_we     = (cnt == '0);
        rec_wvalid = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (32'(cnt) == 32'(need) - 32'd1) begin
          fin                   = 1'b1;
          fin_res.start_address = region_base + (32'(first) << PAGE_SHIFT);
          fin_res.pages         = 11'(need);
          state_next            = S_IDLE;
        end
      end
      S_FIND: begin
        chk_vld_next = rec_iss;
        if (rec_iss) begin
          cnt_next = cnt + 1'b1;
        end
        if (chk_vld && rec_rvalid && (rec_rstart == tgt)) begin
          hit          = 1'b1;
          state_next   = S_RELEASE;
          cnt_next     = '0;
          chk_vld_next = 1'b0;
        end else if (chk_vld && chk_last) begin
          fin            = 1'b1;
          fin_res.status = ST_NOTFOUND;
          state_next     = S_IDLE;
        end
      end
      S_RELEASE: begin
        pg_we      = 1'b1;
        pg_addr    = tgt + cnt[PG_W-1:0];
        rec_addr   = slot;
        rec_we     = (cnt == '0);
        cnt_next   = cnt + 1'b1;
        if (32'(cnt) == 32'(rcount) - 32'd1) begin
          fin           = 1'b1;
          fin_res.pages = 11'(rcount);
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
        cnt_next   = '0;
      end
    endcase

    if (clear_req) begin
      state_next   = S_CLEAR;
      cnt_next     = '0;
      chk_vld_next = 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/first_fit_page_run_allocator_core.sv
`default_nettype none
// First-fit page run allocator.
// Requests: pulse start with req while busy is low; that edge takes the
// transaction. Allocate (req_type 0) rounds req_bytes up to 4 KiB pages and
// claims the lowest free run; free (req_type 1) releases the run that starts
// at req.address. Each request returns exactly one result: done is high for
// one cycle with result valid. There is no back pressure on the result side.
// Flow: small, over-size and out-of-range requests answer from idle, with no scan.
// An allocate scans the page bitmap one page per cycle over the region,
// then the record table one slot per cycle, then writes one page per cycle
// for the run length. A free searches the record table and clears one page
// per cycle. The bitmap and record memories are single-port, and one request
// is in flight at a time.
// Config: cfg_we with cfg_index/cfg_data, only while idle. Writing
// region_pages empties both stores.
// Reset (and each region_pages write) runs a clearing pass over both stores
// with busy high.
module first_fit_page_run_allocator_core
  import ffpa_pkg::*;
#(
  parameter int NPAGES      = NPAGES_DEF,
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire req_t        req,
  output logic             busy,
  output logic             done,
  output res_t             result,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int CNT_W = $clog2(NPAGES + 1);

  logic [31:0]      region_base;
  logic [10:0]      region_pages;
  logic [12:0]      small_limit;
  logic [CNT_W-1:0] eff_pages;
  logic             clear_req;

  assign clear_req = cfg_we && (cfg_idx_t'(cfg_index) == CFG_REGION_PAGES);
  assign eff_pages = (32'(region_pages) > NPAGES) ? CNT_W'(NPAGES) : CNT_W'(region_pages);

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base  <= '0;
      region_pages <= REGION_PAGES_RST;
      small_limit  <= SMALL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REGION_BASE:  region_base  <= cfg_data;
        CFG_REGION_PAGES: region_pages <= cfg_data[10:0];
        CFG_SMALL_LIMIT:  small_limit  <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  ffpa_ctrl #(.NPAGES(NPAGES), .MAX_RECORDS(MAX_RECORDS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req),
    .clear_req  (clear_req),
    .region_base(region_base),
    .eff_pages  (eff_pages),
    .small_limit(small_limit),
    .busy       (busy),
    .done       (done),
    .result     (result)
  );

`include "first_fit_page_run_allocator_core_assert.svh"

  `FFPA_ASSERT_SAME(a_fail_zero, done && (result.status != ST_OK), (result.pages == '0) && (result.start_address == '0))
  `FFPA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)

endmodule
`default_nettype wire

>>> verif/tb_first_fit_page_run_allocator_core.sv
`default_nettype none
module tb_first_fit_page_run_allocator_core
  import ffpa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPG = 1024;
  localparam int NREC = 256;
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;
  localparam int IDLE_LIMIT = 40000;
  localparam int TAIL_CYCLES = 3000;

  class page_run_scoreboard;
    logic [31:0] base;
    logic [10:0] npages_reg;
    logic [12:0] small_lim;
    bit          used[NPG];
    bit          live[NREC];
    int          run_first[NREC];
    int          run_len[NREC];
    int          free_cnt;
    res_t        pending_q[$];
    int          errors;

    function new();
      base = 32'd0;
      npages_reg = REGION_PAGES_RST;
      small_lim = SMALL_LIMIT_RST;
      errors = 0;
      wipe();
    endfunction

    function int region_len();
      return (npages_reg > NPG) ? NPG : int'(npages_reg);
    endfunction

    function void wipe();
      foreach (used[i]) used[i] = 1'b0;
      foreach (live[i]) live[i] = 1'b0;
      free_cnt = region_len();
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_REGION_BASE: base = data;
        CFG_REGION_PAGES: begin
          npages_reg = data[10:0];
          wipe();
        end
        CFG_SMALL_LIMIT: small_lim = data[12:0];
        default: ;
      endcase
    endfunction

    function res_t alloc_run(logic [31:0] bytes);
      res_t r;
      longint need;
      int run, first, slot;
      bit hit;
      r = '{status: ST_OK, start_address: 32'd0, pages: 11'd0};
      if (bytes <= {19'd0, small_lim}) begin
        r.status = ST_SMALL;
        return r;
      end
      need = (longint'(bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
      if (need > free_cnt) begin
        r.status = ST_NOSPACE;
        return r;
      end
      run = 0;
      first = 0;
      hit = 1'b0;
      for (int i = 0; i < region_len(); i++) begin
        if (used[i]) begin
          run = 0;
        end else begin
          if (run == 0) first = i;
          run++;
          if (run == need) begin
            hit = 1'b1;
            break;
          end
        end
      end
      if (!hit) begin
        r.status = ST_NOSPACE;
        return r;
      end
      slot = -1;
      for (int s = 0; s < NREC; s++)
        if (!live[s]) begin
          slot = s;
          break;
        end
      if (slot < 0) begin
        r.status = ST_FULL;
        return r;
      end
      for (int i = first; i < first + int'(need); i++) used[i] = 1'b1;
      live[slot] = 1'b1;
      run_first[slot] = first;
      run_len[slot] = int'(need);
      free_cnt -= int'(need);
      r.start_address = base + 32'(first) * 32'(PAGE_BYTES);
      r.pages = 11'(need);
      return r;
    endfunction

    function res_t release_run(logic [31:0] addr);
      res_t r;
      logic [31:0] off;
      int pg, slot;
      r = '{status: ST_OK, start_address: 32'd0, pages: 11'd0};
      off = addr - base;
      if (longint'(off) >= longint'(region_len()) * PAGE_BYTES) begin
        r.status = ST_OUTSIDE;
        return r;
      end
      if (off[PAGE_SHIFT-1:0] != '0) begin
        r.status = ST_NOTFOUND;
        return r;
      end
      pg = int'(off >> PAGE_SHIFT);
      slot = -1;
      for (int s = 0; s < NREC; s++)
        if (live[s] && run_first[s] == pg) begin
          slot = s;
          break;
        end
      if (slot < 0) begin
        r.status = ST_NOTFOUND;
        return r;
      end
      for (int i = pg; i < pg + run_len[slot] && i < NPG; i++) used[i] = 1'b0;
      live[slot] = 1'b0;
      free_cnt += run_len[slot];
      r.pages = 11'(run_len[slot]);
      return r;
    endfunction

    function void note_request(req_t q);
      pending_q.push_back(q.req_type ? release_run(q.address) : alloc_run(q.req_bytes));
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d addr=%h pages=%0d", $realtime,
                 got.status, got.start_address, got.pages);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, exp_r.status, got.status);
        errors++;
      end
      if (got.start_address !== exp_r.start_address) begin
        $display("%0t: start_address expected %h actual %h", $realtime,
                 exp_r.start_address, got.start_address);
        errors++;
      end
      if (got.pages !== exp_r.pages) begin
        $display("%0t: pages expected %0d actual %0d", $realtime, exp_r.pages, got.pages);
        errors++;
      end
    endfunction

    // random start address of a live run, if any
    function bit pick_live(output logic [31:0] addr);
      int idx[$];
      int k;
      addr = 32'd0;
      foreach (live[s]) if (live[s]) idx.push_back(s);
      if (idx.size() == 0) return 1'b0;
      k = idx[$urandom_range(0, idx.size() - 1)];
      addr = base + 32'(run_first[k]) * 32'(PAGE_BYTES);
      return 1'b1;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  req_t        req = '0;
  logic        busy;
  logic        done;
  res_t        result;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_REGION_BASE;
  logic [31:0] cfg_data = 32'd0;

  page_run_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;

  first_fit_page_run_allocator_core dut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_request(req);
      if (done || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send(input req_t r);
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic alloc(input logic [31:0] bytes);
    send('{req_type: 1'b0, req_bytes: bytes, address: $urandom()});
  endtask

  task automatic release_at(input logic [31:0] addr);
    send('{req_type: 1'b1, req_bytes: $urandom(), address: addr});
  endtask

  task automatic settle();
    pause(1);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    repeat (3) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // one random transaction, sender in bursts
  task automatic random_item(input int big_pct);
    int mode, npg;
    logic [31:0] a;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 20));
      burst_left = $urandom_range(1, 25);
    end
    burst_left--;
    mode = $urandom_range(0, 99);
    if (mode < 50) begin
      npg = ($urandom_range(0, 99) < big_pct) ? $urandom_range(1, sb.region_len() + 1)
                                               : $urandom_range(1, 8);
      alloc(32'(npg - 1) * 32'(PAGE_BYTES) + $urandom_range(1, PAGE_BYTES));
    end else if (mode < 82) begin
      if (!sb.pick_live(a)) a = sb.base + 32'($urandom_range(0, NPG)) * 32'(PAGE_BYTES);
      release_at(a);
    end else if (mode < 88) begin
      release_at(sb.base + 32'($urandom_range(0, NPG)) * 32'(PAGE_BYTES));
    end else if (mode < 94) begin
      alloc($urandom());
    end else begin
      release_at($urandom());
    end
  endtask

  initial begin
    logic [31:0] a;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);
    while (busy) @(posedge clk);

    // directed: reset settings
    alloc(32'd0);
    alloc(32'd2048);
    alloc(32'd2049);
    alloc(32'd4097);
    alloc(32'hFFFF_FFFF);
    release_at(32'd0);
    release_at(32'd0);
    release_at(32'd4097);
    release_at(32'hFFFF_F000);
    alloc(32'd4 * 32'd1024 * 32'd1024 - 32'd4096);
    alloc(32'd4096);
    release_at(32'd4096);
    release_at(32'h0040_0000);

    // directed: fragmented small region, wrapped base
    cfg_write(CFG_REGION_BASE, 32'hFFFF_E000);
    cfg_write(CFG_REGION_PAGES, 32'd4);
    cfg_write(CFG_SMALL_LIMIT, 32'd0);
    alloc(32'd1);
    alloc(32'd4096);
    alloc(32'd4096);
    release_at(32'hFFFF_F000);
    alloc(32'd8192);
    alloc(32'd4096);
    release_at(32'h0000_1000);
    release_at(32'h0000_2000);

    // directed: empty region, ignored register index
    cfg_write(CFG_REGION_PAGES, 32'd0);
    cfg_write(CFG_UNMAPPED, 32'hFFFF_FFFF);
    alloc(32'd1);
    release_at(32'hFFFF_E000);

    cfg_write(CFG_REGION_BASE, 32'd0);
    cfg_write(CFG_REGION_PAGES, 32'd1024);
    cfg_write(CFG_SMALL_LIMIT, 32'd2048);
    repeat (150) random_item(5);

    // fill the record table with single pages
    cfg_write(CFG_SMALL_LIMIT, 32'd0);
    cfg_write(CFG_REGION_PAGES, 32'd1024);
    repeat (275) begin
      if ($urandom_range(0, 9) == 0) pause($urandom_range(1, 10));
      alloc($urandom_range(1, PAGE_BYTES));
    end
    repeat (30) begin
      if (sb.pick_live(a)) release_at(a);
      if ($urandom_range(0, 3) == 0) alloc($urandom_range(1, 3 * PAGE_BYTES));
    end

    cfg_write(CFG_REGION_BASE, 32'hFFFF_C000);
    cfg_write(CFG_REGION_PAGES, 32'd37);
    cfg_write(CFG_SMALL_LIMIT, 32'd4096);
    repeat (80) random_item(30);

    cfg_write(CFG_REGION_BASE, $urandom());
    cfg_write(CFG_REGION_PAGES, 32'h7FF);
    cfg_write(CFG_SMALL_LIMIT, 32'h1FFF);
    repeat (60) random_item(5);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
